@@ rtl/flr_pkg.sv @@
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants for the framed link receiver: channel words,
// the verified-frame hand-over between parser and unpacker, and frame codes.
// ----------------------------------------------------------------------------
package flr_pkg;

    // Default depth of the frame buffer; a frame that fills it is dropped.
    localparam int BUFFER_DEPTH_DEFAULT = 64;

    // Reset value of the device address register.
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h05;

    // Framing bytes and positions within a frame.
    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam int         ID_POS     = 2;
    localparam int         LEN_POS    = 3;
    localparam int         HDR_BYTES  = 4;

    // Decoding only ever looks at the first DECODE_SPAN bytes of a frame.
    localparam int DECODE_SPAN = 32;
    localparam int SPAN_IDX_W  = $clog2(DECODE_SPAN);
    localparam int SNAP_BYTES  = DECODE_SPAN - HDR_BYTES;

    // Frame identifiers that produce results.
    localparam logic [7:0] ID_CHASSIS  = 8'h12;
    localparam logic [7:0] ID_KEYBOARD = 8'h14;
    localparam logic [7:0] ID_ARM      = 8'h21;

    // Result kind codes.
    localparam logic [1:0] KIND_CHASSIS  = 2'd0;
    localparam logic [1:0] KIND_KEYBOARD = 2'd1;
    localparam logic [1:0] KIND_ARM      = 2'd2;

    // Input word: one link byte and the transfer-start flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
    } in_word_t;

    // Output word: one decoded value of a frame.
    typedef struct packed {
        logic [1:0]         frame_kind;
        logic [3:0]         value_index;
        logic signed [31:0] value;
        logic               last;
    } out_word_t;

    // Verified frame handed from the parser to the unpacker.
    typedef struct packed {
        logic                           load;
        logic [1:0]                     kind;
        logic [SNAP_BYTES-1:0][7:0]     bytes;
    } flr_frame_t;

endpackage

@@ rtl/flr_parser.sv @@
// ----------------------------------------------------------------------------
// flr_parser
// Byte-by-byte frame parser: checks start byte, address, length and both
// checksums, stores the frame bytes and hands a verified frame onwards.
// ----------------------------------------------------------------------------
module flr_parser #(
    parameter int BUFFER_DEPTH = flr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  flr_pkg::in_word_t   rx_word,
    input  logic                unpack_busy,
    output flr_pkg::flr_frame_t frame
);

    localparam int CW    = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = CW + 8;
    localparam int SPAN  = flr_pkg::DECODE_SPAN;
    localparam int IW    = flr_pkg::SPAN_IDX_W;

    typedef enum logic [2:0] {
        PH_START,
        PH_ADDR,
        PH_ID,
        PH_BODY,
        PH_SUM,
        PH_SUMSUM
    } phase_t;

    phase_t              phase_reg, phase_next, ph_eff;
    logic [CW-1:0]       cnt_reg, cnt_next, cnt_eff, cnt_inc;
    logic [7:0]          rsum_reg, rsum_next, rsum_eff, rsum_inc;
    logic [7:0]          ssum_reg, ssum_next, ssum_eff, ssum_inc;
    logic [SPAN-1:0]     valid_reg, valid_next, valid_eff;
    logic [7:0]          buf_reg [SPAN];
    logic [7:0]          addr_reg;
    logic [7:0]          b;
    logic [7:0]          len_byte;
    logic [7:0]          id_byte;
    logic [SPAN-1:0][7:0] rd;
    logic                accept;
    logic                store;
    logic                drop;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    logic                len_match;
    logic                sum_ok;

    // The parser holds off only a closing byte while a previous frame unpacks.
    assign rx_stall = (phase_reg == PH_SUMSUM) && unpack_busy;
    assign accept   = rx_valid && !rx_stall;
    assign b        = rx_word.rx_byte;

    // A transfer start wipes the state before the word is looked at.
    always_comb
    begin
        ph_eff    = rx_word.packet_start ? PH_START : phase_reg;
        cnt_eff   = rx_word.packet_start ? '0 : cnt_reg;
        rsum_eff  = rx_word.packet_start ? '0 : rsum_reg;
        ssum_eff  = rx_word.packet_start ? '0 : ssum_reg;
        valid_eff = rx_word.packet_start ? '0 : valid_reg;
    end

    // Buffer reads; entries not written since the last clear read as zero.
    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            rd[i] = valid_eff[i] ? buf_reg[i] : 8'h00;
        end
    end

    assign cnt_inc  = cnt_eff + CW'(1);
    assign rsum_inc = rsum_eff + b;
    assign ssum_inc = ssum_eff + rsum_inc;
    assign id_byte  = rd[flr_pkg::ID_POS];

    // The length byte may be the very word being stored.
    assign len_byte  = (cnt_inc == CW'(flr_pkg::HDR_BYTES)) ? b : rd[flr_pkg::LEN_POS];
    assign len_match = (cnt_inc >= CW'(flr_pkg::HDR_BYTES)) &&
                       ((CMP_W'(cnt_inc) - CMP_W'(flr_pkg::HDR_BYTES)) == CMP_W'(len_byte));
    assign sum_ok    = (ssum_eff == b);
    assign wr_idx    = cnt_eff[IW-1:0];

    // Phase sequencing, running checksums and the frame hand-over.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rsum_next  = rsum_reg;
        ssum_next  = ssum_reg;
        valid_next = valid_reg;
        store      = 1'b0;
        drop       = 1'b0;
        wr_en      = 1'b0;
        frame.load = 1'b0;
        frame.kind = flr_pkg::KIND_CHASSIS;
        // Snapshot of the decodable payload bytes for the unpacker.
        for (int i = 0; i < flr_pkg::SNAP_BYTES; i++)
        begin
            frame.bytes[i] = rd[i + flr_pkg::HDR_BYTES];
        end
        if (accept)
        begin
            phase_next = ph_eff;
            cnt_next   = cnt_eff;
            rsum_next  = rsum_eff;
            ssum_next  = ssum_eff;
            valid_next = valid_eff;
            unique case (ph_eff)
                PH_START:
                begin
                    if (b == flr_pkg::START_BYTE)
                    begin
                        store      = 1'b1;
                        phase_next = PH_ADDR;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                PH_ADDR:
                begin
                    if (b == addr_reg)
                    begin
                        store      = 1'b1;
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                PH_ID:
                begin
                    store      = 1'b1;
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    store = 1'b1;
                    if (len_match)
                    begin
                        phase_next = PH_SUM;
                    end
                    if (cnt_inc >= CW'(BUFFER_DEPTH))
                    begin
                        drop = 1'b1;
                    end
                end
                PH_SUM:
                begin
                    if (rsum_eff == b)
                    begin
                        phase_next = PH_SUMSUM;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                PH_SUMSUM:
                begin
                    drop = 1'b1;
                    if (sum_ok)
                    begin
                        unique case (id_byte)
                            flr_pkg::ID_CHASSIS:
                            begin
                                frame.load = 1'b1;
                                frame.kind = flr_pkg::KIND_CHASSIS;
                            end
                            flr_pkg::ID_KEYBOARD:
                            begin
                                frame.load = 1'b1;
                                frame.kind = flr_pkg::KIND_KEYBOARD;
                            end
                            flr_pkg::ID_ARM:
                            begin
                                frame.load = 1'b1;
                                frame.kind = flr_pkg::KIND_ARM;
                            end
                            default:
                            begin
                                frame.load = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    drop = 1'b1;
                end
            endcase
            if (store)
            begin
                cnt_next  = cnt_inc;
                rsum_next = rsum_inc;
                ssum_next = ssum_inc;
                if (cnt_eff < CW'(SPAN))
                begin
                    wr_en              = 1'b1;
                    valid_next[wr_idx] = 1'b1;
                end
            end
            if (drop)
            begin
                phase_next = PH_START;
                cnt_next   = '0;
                rsum_next  = '0;
                ssum_next  = '0;
            end
        end
    end

    // Control state and the address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cnt_reg   <= '0;
            rsum_reg  <= '0;
            ssum_reg  <= '0;
            valid_reg <= '0;
            addr_reg  <= flr_pkg::DEVICE_ADDRESS_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rsum_reg  <= rsum_next;
            ssum_reg  <= ssum_next;
            valid_reg <= valid_next;
            if (cfg_write)
            begin
                addr_reg <= cfg_data;
            end
        end
    end

    // Frame buffer. Bytes past the decode span are counted but never read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[wr_idx] <= b;
        end
    end

`ifndef NO_ASSERTIONS
    // A closing byte without a transfer start always ends the frame, pass or fail.
    a_sumsum_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_SUMSUM) && !rx_word.packet_start)
        |=> (phase_reg == PH_START))
        else $error("parser did not return to start after the sum of sums");

    // The stored byte count never reaches the buffer depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CW'(BUFFER_DEPTH))
        else $error("byte count reached the buffer depth");

    // Waiting for a start byte means nothing of a frame is counted.
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_START) |-> (cnt_reg == '0) && (rsum_reg == '0))
        else $error("parser idle with frame state left over");
`endif

endmodule

@@ rtl/flr_unpacker.sv @@
// ----------------------------------------------------------------------------
// flr_unpacker
// Holds a verified frame and issues its decoded values one per cycle into
// the result register, honouring the downstream stall.
// ----------------------------------------------------------------------------
module flr_unpacker (
    input  logic                clk,
    input  logic                rst_n,
    input  flr_pkg::flr_frame_t frame,
    output logic                busy,
    output logic                res_valid,
    input  logic                res_stall,
    output flr_pkg::out_word_t  res_word
);

    logic [1:0]                           kind_reg;
    logic [flr_pkg::SNAP_BYTES-1:0][7:0]  bytes_reg;
    logic [3:0]                           pend_reg;
    logic [3:0]                           idx_reg;
    logic                                 out_valid_reg;
    flr_pkg::out_word_t                   out_reg;
    logic                                 out_free;
    logic                                 issue;

    // Number of values a frame of the given kind produces.
    function automatic logic [3:0] value_count(input logic [1:0] kind);
        logic [3:0] n;
        n = 4'd0;
        unique case (kind)
            flr_pkg::KIND_CHASSIS:  n = 4'd3;
            flr_pkg::KIND_KEYBOARD: n = 4'd1;
            flr_pkg::KIND_ARM:      n = 4'd9;
            default:                n = 4'd0;
        endcase
        return n;
    endfunction

    // Little-endian word starting at the given snapshot byte.
    function automatic logic [31:0] word_at(
        input logic [flr_pkg::SNAP_BYTES-1:0][7:0] bytes,
        input int                                  pos
    );
        return {bytes[pos + 3], bytes[pos + 2], bytes[pos + 1], bytes[pos]};
    endfunction

    // Value selected by frame kind and position. Snapshot byte 0 is frame byte 4.
    function automatic logic [31:0] value_of(
        input logic [1:0]                          kind,
        input logic [3:0]                          idx,
        input logic [flr_pkg::SNAP_BYTES-1:0][7:0] bytes
    );
        logic [31:0] v;
        v = 32'd0;
        if (kind == flr_pkg::KIND_CHASSIS)
        begin
            unique case (idx)
                4'd0:    v = word_at(bytes, 0);
                4'd1:    v = word_at(bytes, 4);
                default: v = word_at(bytes, 20);
            endcase
        end
        else if (kind == flr_pkg::KIND_KEYBOARD)
        begin
            v = {16'd0, bytes[1], bytes[0]};
        end
        else
        begin
            unique case (idx)
                4'd0:    v = word_at(bytes, 0);
                4'd1:    v = word_at(bytes, 4);
                4'd2:    v = word_at(bytes, 8);
                4'd3:    v = word_at(bytes, 12);
                4'd4:    v = word_at(bytes, 16);
                4'd5:    v = word_at(bytes, 20);
                4'd6:    v = {24'd0, bytes[24]};
                4'd7:    v = {24'd0, bytes[25]};
                default: v = {{24{bytes[26][7]}}, bytes[26]};
            endcase
        end
        return v;
    endfunction

    assign busy     = (pend_reg != 4'd0);
    assign out_free = !out_valid_reg || !res_stall;
    assign issue    = busy && out_free;

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    // Issue sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 4'd0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame.load)
            begin
                pend_reg <= value_count(frame.kind);
                idx_reg  <= 4'd0;
            end
            else if (issue)
            begin
                pend_reg <= pend_reg - 4'd1;
                idx_reg  <= idx_reg + 4'd1;
            end
            if (out_free)
            begin
                out_valid_reg <= busy;
            end
        end
    end

    // Frame snapshot and result word.
    always_ff @(posedge clk)
    begin
        if (frame.load)
        begin
            kind_reg  <= frame.kind;
            bytes_reg <= frame.bytes;
        end
        if (issue)
        begin
            out_reg.frame_kind  <= kind_reg;
            out_reg.value_index <= idx_reg;
            out_reg.value       <= value_of(kind_reg, idx_reg, bytes_reg);
            out_reg.last        <= (pend_reg == 4'd1);
        end
    end

`ifndef NO_ASSERTIONS
    // A new frame only arrives once the previous one has been issued.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame.load |-> !busy)
        else $error("frame loaded while values still pending");

    // Issued plus pending values always make up the whole frame.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((idx_reg + pend_reg) == value_count(kind_reg)))
        else $error("value position and remaining count disagree");

    // Issuing the final pending value presents a word marked last.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && (pend_reg == 4'd1)) |=> (out_valid_reg && out_reg.last))
        else $error("final value of a frame not marked last");
`endif

endmodule

@@ rtl/framed_link_receiver_top.sv @@
// ----------------------------------------------------------------------------
// framed_link_receiver_top
// Framed link receiver: parses a checksummed byte stream and emits the
// decoded values of each verified frame.
// ----------------------------------------------------------------------------
// Usage:
//   The receive channel (rx_valid, rx_stall, rx_word) takes one link byte per
//   word with a transfer-start flag; a word is accepted when rx_valid is high
//   and rx_stall low. The result channel (res_valid, res_stall, res_word)
//   carries one decoded value per word, with last set on the final value.
//   The device address register is written through cfg_write and cfg_data
//   while the block is idle.
//   Throughput is one byte per cycle. The closing sum-of-sums byte of a
//   frame is held off while the values of the previous frame are still
//   being issued from the frame snapshot, one per cycle while res_stall is
//   low, and at most nine.
//   Once the closing byte is accepted the frame snapshot is loaded; each value
//   then passes through the result register, one per cycle while not stalled.
//   When res_stall is high the result word holds, the sequencer waits and
//   ordinary bytes keep being accepted.
//   Reset clears the parser, the buffer valid bits and the result channel,
//   and sets the device address to 5.
// ----------------------------------------------------------------------------
module framed_link_receiver_top #(
    parameter int BUFFER_DEPTH = flr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_data,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  flr_pkg::in_word_t  rx_word,
    output logic               res_valid,
    input  logic               res_stall,
    output flr_pkg::out_word_t res_word
);

    flr_pkg::flr_frame_t frame;
    logic                unpack_busy;

    // Frame parser and checksum checker.
    flr_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_word     (rx_word),
        .unpack_busy (unpack_busy),
        .frame       (frame)
    );

    // Value sequencer and result register.
    flr_unpacker u_unpacker (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .busy      (unpack_busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

@@ verif/framed_link_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed link receiver. Frames are built with
// their running sum and sum of sums and sent one byte per word. A shadow
// parser follows every accepted word and queues the values that a verified
// frame should produce. Each result word is compared with the oldest queued
// value. Directed frames come first, then random traffic under varied idling
// and device address settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BUF_DEPTH   = flr_pkg::BUFFER_DEPTH_DEFAULT;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 12;

    typedef enum logic [2:0] {
        WAIT_START, WAIT_ADDR, WAIT_ID, IN_BODY, WAIT_SUM, WAIT_SUMSUM
    } parse_phase_t;

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SUMSUM} frame_fault_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [7:0]         cfg_data  = 8'h00;
    logic               rx_valid  = 1'b0;
    logic               rx_stall;
    flr_pkg::in_word_t  rx_word   = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    flr_pkg::out_word_t res_word;

    // Shadow copy of the parser state and the address register.
    parse_phase_t phase        = WAIT_START;
    int           kept_count   = 0;
    logic [7:0]   run_sum      = 8'h00;
    logic [7:0]   sum_of_sums  = 8'h00;
    logic [7:0]   frame_store [BUF_DEPTH] = '{default: 8'h00};
    logic [7:0]   link_address = flr_pkg::DEVICE_ADDRESS_RESET;

    flr_pkg::out_word_t pending_values[$];

    int  fail_count         = 0;
    int  bytes_sent         = 0;
    int  quiet_cycles       = 0;
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    bit  stray_starts       = 1'b0;

    framed_link_receiver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always #4 clk = ~clk;

    // The receiver holds off result words at random.
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------

    // Abandon the current frame; the buffer contents are kept.
    function automatic void restart_parser();
        phase       = WAIT_START;
        kept_count  = 0;
        run_sum     = 8'h00;
        sum_of_sums = 8'h00;
    endfunction

    // Store one frame byte and advance both checksums.
    function automatic void keep_byte(logic [7:0] b);
        if (kept_count < BUF_DEPTH)
        begin
            frame_store[kept_count] = b;
            kept_count++;
            run_sum     = run_sum + b;
            sum_of_sums = sum_of_sums + run_sum;
        end
        else
        begin
            kept_count  = 0;
            run_sum     = 8'h00;
            sum_of_sums = 8'h00;
        end
    endfunction

    function automatic logic [31:0] le_word(int pos);
        return {frame_store[pos + 3], frame_store[pos + 2],
                frame_store[pos + 1], frame_store[pos]};
    endfunction

    function automatic void add_value(logic [1:0] kind, int idx, logic [31:0] v, bit fin);
        flr_pkg::out_word_t e;
        e.frame_kind  = kind;
        e.value_index = idx[3:0];
        e.value       = v;
        e.last        = fin;
        pending_values.push_back(e);
    endfunction

    // Queue the values of a verified frame, chosen by its id.
    function automatic void unpack_frame();
        unique case (frame_store[flr_pkg::ID_POS])
            flr_pkg::ID_CHASSIS:
            begin
                add_value(flr_pkg::KIND_CHASSIS, 0, le_word(4), 1'b0);
                add_value(flr_pkg::KIND_CHASSIS, 1, le_word(8), 1'b0);
                add_value(flr_pkg::KIND_CHASSIS, 2, le_word(24), 1'b1);
            end
            flr_pkg::ID_KEYBOARD:
            begin
                add_value(flr_pkg::KIND_KEYBOARD, 0,
                          {16'h0000, frame_store[5], frame_store[4]}, 1'b1);
            end
            flr_pkg::ID_ARM:
            begin
                for (int i = 0; i < 6; i++)
                    add_value(flr_pkg::KIND_ARM, i, le_word(4 + 4 * i), 1'b0);
                add_value(flr_pkg::KIND_ARM, 6, {24'h000000, frame_store[28]}, 1'b0);
                add_value(flr_pkg::KIND_ARM, 7, {24'h000000, frame_store[29]}, 1'b0);
                add_value(flr_pkg::KIND_ARM, 8,
                          {{24{frame_store[30][7]}}, frame_store[30]}, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Follow one accepted link word through the frame syntax.
    function automatic void parse_link_byte(flr_pkg::in_word_t w);
        logic [7:0] b;
        bit         sums_match;
        b = w.rx_byte;
        if (w.packet_start)
        begin
            restart_parser();
            frame_store = '{default: 8'h00};
        end
        if (phase == WAIT_START && b == flr_pkg::START_BYTE)
        begin
            keep_byte(b);
            phase = WAIT_ADDR;
        end
        else if (phase == WAIT_ADDR && b == link_address)
        begin
            keep_byte(b);
            phase = WAIT_ID;
        end
        else if (phase == WAIT_ID)
        begin
            keep_byte(b);
            phase = IN_BODY;
        end
        else if (phase == IN_BODY)
        begin
            keep_byte(b);
            if (kept_count >= flr_pkg::HDR_BYTES &&
                kept_count - flr_pkg::HDR_BYTES == int'(frame_store[flr_pkg::LEN_POS]))
                phase = WAIT_SUM;
            if (kept_count >= BUF_DEPTH)
                restart_parser();
        end
        else if (phase == WAIT_SUM)
        begin
            if (run_sum == b)
                phase = WAIT_SUMSUM;
            else
                restart_parser();
        end
        else if (phase == WAIT_SUMSUM)
        begin
            sums_match = (sum_of_sums == b);
            restart_parser();
            if (sums_match)
                unpack_frame();
        end
        else
        begin
            restart_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void check_value(flr_pkg::out_word_t got);
        flr_pkg::out_word_t want;
        if (pending_values.size() == 0)
        begin
            note_failure($sformatf("unexpected value word: kind %0d index %0d value %0d last %0b",
                                   got.frame_kind, got.value_index, got.value, got.last));
            return;
        end
        want = pending_values.pop_front();
        if (got.frame_kind !== want.frame_kind || got.value_index !== want.value_index ||
            got.value !== want.value || got.last !== want.last)
            note_failure($sformatf({"value mismatch: expected kind %0d index %0d value %0d ",
                                    "last %0b, got kind %0d index %0d value %0d last %0b"},
                                   want.frame_kind, want.value_index, want.value, want.last,
                                   got.frame_kind, got.value_index, got.value, got.last));
    endfunction

    // Check results first, then follow the input word; the watchdog ends a hung run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_value(res_word);
            if (rx_valid && !rx_stall)
                parse_link_byte(rx_word);
            if ((res_valid && !res_stall) || (rx_valid && !rx_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic s);
        flr_pkg::in_word_t w;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        w.rx_byte      = b;
        w.packet_start = s;
        rx_word  <= w;
        rx_valid <= 1'b1;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
    endtask

    // Hold the sender back until every queued value has been seen.
    task automatic wait_for_results();
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending_values.size() != 0);
    endtask

    // Change the device address once the block has gone quiet.
    task automatic set_link_address(input logic [7:0] a);
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        cfg_write    <= 1'b0;
        link_address = a;
    endtask

    // Build a frame with its two checksums, optionally spoiling one of them.
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] id,
                              input logic [7:0] body[$], input frame_fault_t fault,
                              input bit fresh);
        logic [7:0] frame_bytes[$];
        logic [7:0] rs;
        logic [7:0] ss;
        bit         s;
        frame_bytes = {flr_pkg::START_BYTE, addr, id, 8'(body.size())};
        frame_bytes = {frame_bytes, body};
        rs = 8'h00;
        ss = 8'h00;
        foreach (frame_bytes[i])
        begin
            rs = rs + frame_bytes[i];
            ss = ss + rs;
        end
        if (fault == FRAME_BAD_SUM)
            rs = rs ^ 8'($urandom_range(255, 1));
        if (fault == FRAME_BAD_SUMSUM)
            ss = ss ^ 8'($urandom_range(255, 1));
        frame_bytes.push_back(rs);
        frame_bytes.push_back(ss);
        foreach (frame_bytes[i])
        begin
            s = (i == 0 && fresh) || (stray_starts && $urandom_range(199) == 0);
            send_byte(frame_bytes[i], s);
        end
    endtask

    // One random unit of traffic: mostly frames, some line noise.
    task automatic random_frame();
        logic [7:0]   body[$];
        logic [7:0]   id;
        logic [7:0]   addr;
        frame_fault_t fault;
        int           len;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            repeat ($urandom_range(4, 1))
                send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 30)
            id = flr_pkg::ID_CHASSIS;
        else if (pick < 55)
            id = flr_pkg::ID_KEYBOARD;
        else if (pick < 80)
            id = flr_pkg::ID_ARM;
        else
            id = 8'($urandom_range(255));
        // Mostly short frames; a few reach or overrun the end of the buffer.
        len = ($urandom_range(9) == 0) ? $urandom_range(61, 28) : $urandom_range(27, 0);
        repeat (len)
            body.push_back(8'($urandom_range(255)));
        addr  = link_address;
        fault = FRAME_GOOD;
        pick  = $urandom_range(99);
        if (pick < 6)
            fault = FRAME_BAD_SUM;
        else if (pick < 12)
            fault = FRAME_BAD_SUMSUM;
        else if (pick < 17)
            addr = addr ^ 8'($urandom_range(255, 1));
        send_frame(addr, id, body, fault, $urandom_range(9) == 0);
        if ($urandom_range(19) == 0)
            wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each frame id, with extreme word values and both signs of the last byte.
    task automatic test_frame_kinds();
        logic [7:0] body[$];
        body = {};
        send_frame(link_address, flr_pkg::ID_CHASSIS, body, FRAME_GOOD, 1'b1);
        body = {8'hFF, 8'hFF};
        send_frame(link_address, flr_pkg::ID_KEYBOARD, body, FRAME_GOOD, 1'b0);
        body = {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h80,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        repeat (8)
            body.push_back(8'($urandom_range(255)));
        body = {body, 8'hFF, 8'h00, 8'h80};
        send_frame(link_address, flr_pkg::ID_ARM, body, FRAME_GOOD, 1'b0);
        body[26] = 8'h7F;
        send_frame(link_address, flr_pkg::ID_ARM, body, FRAME_GOOD, 1'b0);
        body = {8'h01, 8'h02, 8'h03, 8'h04};
        send_frame(link_address, 8'h13, body, FRAME_GOOD, 1'b0);
    endtask

    // Noise, a wrong address and each failing check, then a clean frame.
    task automatic test_framing_errors();
        logic [7:0] body[$];
        body = {8'h34, 8'h12};
        send_byte(8'h00, 1'b0);
        send_frame(link_address ^ 8'h01, flr_pkg::ID_KEYBOARD, body, FRAME_GOOD, 1'b0);
        send_frame(link_address, flr_pkg::ID_KEYBOARD, body, FRAME_BAD_SUM, 1'b0);
        send_frame(link_address, flr_pkg::ID_KEYBOARD, body, FRAME_BAD_SUMSUM, 1'b0);
        send_frame(link_address, flr_pkg::ID_KEYBOARD, body, FRAME_GOOD, 1'b0);
    endtask

    // A frame that fills the buffer, then a short frame that decodes the
    // bytes left behind.
    task automatic test_buffer_overflow();
        logic [7:0] body[$];
        body = {};
        repeat (60)
            body.push_back(8'($urandom_range(255)));
        send_frame(link_address, flr_pkg::ID_ARM, body, FRAME_GOOD, 1'b1);
        body = {};
        send_frame(link_address, flr_pkg::ID_CHASSIS, body, FRAME_GOOD, 1'b0);
    endtask

    // The start flag cuts a frame short and clears the buffer.
    task automatic test_packet_start();
        logic [7:0] body[$];
        send_byte(flr_pkg::START_BYTE, 1'b0);
        send_byte(link_address, 1'b0);
        send_byte(flr_pkg::ID_ARM, 1'b0);
        send_byte(8'd10, 1'b0);
        send_byte(8'hA5, 1'b0);
        body = {};
        send_frame(link_address, flr_pkg::ID_ARM, body, FRAME_GOOD, 1'b1);
        send_byte(8'h00, 1'b1);
        body = {8'h80, 8'h00};
        send_frame(link_address, flr_pkg::ID_KEYBOARD, body, FRAME_GOOD, 1'b0);
    endtask

    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic [7:0] addr);
        int first_byte;
        set_link_address(addr);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < PHASE_BYTES)
            random_frame();
    endtask

    // Random traffic through each idling pattern and several addresses.
    task automatic test_random_traffic();
        stray_starts = 1'b1;
        run_traffic_phase(0, 0, 8'h00);
        run_traffic_phase(46, 0, 8'hFF);
        run_traffic_phase(0, 46, 8'($urandom_range(254, 1)));
        run_traffic_phase(35, 35, flr_pkg::DEVICE_ADDRESS_RESET);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_frame_kinds();
        test_framing_errors();
        test_buffer_overflow();
        test_packet_start();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_values.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
